// ----- src/tlsf_free_class_bitmap_engine_unit_macros.svh -----
// assertion macros shared by the tlsf class bitmap engine
`ifndef TLSF_FREE_CLASS_BITMAP_ENGINE_UNIT_MACROS_SVH
`define TLSF_FREE_CLASS_BITMAP_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define TFCB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TFCB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/tlsf_fcb_pkg.sv -----
// shared types and constants of the tlsf class bitmap engine
package tlsf_fcb_pkg;

    localparam int SIZE_W            = 48;
    localparam int REQ_W             = 2;
    localparam int STATUS_W          = 2;
    localparam int FL_OUT_W          = 5;
    localparam int SL_OUT_W          = 4;
    localparam int FL_IDX_W          = 5;
    localparam int SL_IDX_W          = 5;
    localparam int MIN_PAYLOAD_BYTES = 16;

    localparam int DEF_FIRST_LEVELS      = 30;
    localparam int DEF_SECOND_LEVEL_LOG2 = 4;
    localparam int DEF_ALIGN_LOG2_BYTES  = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_SEARCH = 2'd0,
        REQ_MARK   = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req_kind;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_NOFIT = 2'd1,
        STAT_RANGE = 2'd2
    } t_status;

    // classified request handed from front to back
    typedef struct packed {
        t_req_kind           kind;
        logic                bad;
        logic [FL_IDX_W-1:0] fl;
        logic [SL_IDX_W-1:0] sl;
    } t_class_item;

endpackage

// ----- src/tlsf_fcb_front.sv -----
// front end: size rounding and class mapping, two stages
module tlsf_fcb_front #(
    parameter int FIRST_LEVELS      = tlsf_fcb_pkg::DEF_FIRST_LEVELS,
    parameter int SECOND_LEVEL_LOG2 = tlsf_fcb_pkg::DEF_SECOND_LEVEL_LOG2,
    parameter int ALIGN_LOG2_BYTES  = tlsf_fcb_pkg::DEF_ALIGN_LOG2_BYTES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    output logic                             o_full,
    input  logic [tlsf_fcb_pkg::REQ_W-1:0]   i_req_type,
    input  logic [tlsf_fcb_pkg::SIZE_W-1:0]  i_size,
    output logic                             o_item_push,
    output tlsf_fcb_pkg::t_class_item        o_item,
    input  logic                             i_item_full
);

    localparam int RND_W       = tlsf_fcb_pkg::SIZE_W + 1;
    localparam int LEAD_W      = $clog2(RND_W);
    localparam int EXP_W       = LEAD_W + 1;
    localparam int SL          = SECOND_LEVEL_LOG2;
    localparam int CLASS_SHIFT = SECOND_LEVEL_LOG2 + ALIGN_LOG2_BYTES;
    localparam int ALIGN_BYTES = 1 << ALIGN_LOG2_BYTES;

    typedef struct packed {
        tlsf_fcb_pkg::t_req_kind kind;
        logic                    bad;
        logic [RND_W-1:0]        s;
        logic [LEAD_W-1:0]       lead;
    } t_stage_a;

    function automatic logic [LEAD_W-1:0] f_lead(input logic [RND_W-1:0] x);
        logic [LEAD_W-1:0] p;
        p = '0;
        for (int i = 0; i < RND_W; i++) begin
            if (x[i]) begin
                p = LEAD_W'(i);
            end
        end
        return p;
    endfunction

    logic                     r_a_valid;
    logic                     n_a_valid;
    t_stage_a                 r_a;
    t_stage_a                 n_a;
    logic                     accept;
    logic                     kind_ok;
    logic [RND_W-1:0]         size_ext;
    logic [RND_W-1:0]         rounded;

    logic                     in_linear;
    logic [LEAD_W-1:0]        sh;
    logic [RND_W-1:0]         shifted;
    logic                     sticky;
    logic                     inc;
    logic [SL+1:0]            mant;
    logic [EXP_W-1:0]         fl_full;
    logic                     oor;
    logic [SL-1:0]            sl_sel;
    logic [tlsf_fcb_pkg::FL_IDX_W-1:0] fl_sel;

    assign o_full      = r_a_valid && i_item_full;
    assign accept      = i_push && !o_full;
    assign o_item_push = r_a_valid && !i_item_full;

    // stage a: alignment round-up and leading one
    always_comb begin
        kind_ok  = (i_req_type == tlsf_fcb_pkg::REQ_SEARCH) ||
                   (i_req_type == tlsf_fcb_pkg::REQ_MARK) ||
                   (i_req_type == tlsf_fcb_pkg::REQ_CLEAR);
        size_ext = {1'b0, i_size};
        rounded  = (size_ext + RND_W'(ALIGN_BYTES - 1)) & ~RND_W'(ALIGN_BYTES - 1);
        if (rounded < RND_W'(tlsf_fcb_pkg::MIN_PAYLOAD_BYTES)) begin
            rounded = RND_W'(tlsf_fcb_pkg::MIN_PAYLOAD_BYTES);
        end
        n_a.kind = tlsf_fcb_pkg::REQ_SEARCH;
        n_a.s    = rounded;
        if (i_req_type == tlsf_fcb_pkg::REQ_MARK) begin
            n_a.kind = tlsf_fcb_pkg::REQ_MARK;
            n_a.s    = size_ext;
        end else if (i_req_type == tlsf_fcb_pkg::REQ_CLEAR) begin
            n_a.kind = tlsf_fcb_pkg::REQ_CLEAR;
            n_a.s    = size_ext;
        end
        n_a.bad  = !kind_ok || (i_size == '0);
        n_a.lead = f_lead(n_a.s);
    end

    always_comb begin
        n_a_valid = r_a_valid;
        if (accept) begin
            n_a_valid = 1'b1;
        end else if (o_item_push) begin
            n_a_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a <= n_a;
        end
    end

    // stage b: class boundary round-up and class index
    always_comb begin
        in_linear = r_a.lead < LEAD_W'(CLASS_SHIFT);
        sh      = r_a.lead - LEAD_W'(SL);
        shifted = r_a.s >> sh;
        sticky  = |(r_a.s & ~({RND_W{1'b1}} << sh));
        inc     = (r_a.kind == tlsf_fcb_pkg::REQ_SEARCH) && sticky;
        mant    = {1'b0, shifted[SL:0]} + (SL + 2)'(inc);
        fl_full = {1'b0, r_a.lead} + EXP_W'(mant[SL + 1]) - EXP_W'(CLASS_SHIFT - 1);
        oor     = !in_linear && (fl_full >= EXP_W'(FIRST_LEVELS));
        if (in_linear) begin
            sl_sel = r_a.s[CLASS_SHIFT-1:ALIGN_LOG2_BYTES];
            fl_sel = '0;
        end else begin
            sl_sel = mant[SL-1:0];
            fl_sel = fl_full[tlsf_fcb_pkg::FL_IDX_W-1:0];
        end
        o_item.kind = r_a.kind;
        o_item.bad  = r_a.bad || oor;
        o_item.fl   = o_item.bad ? '0 : fl_sel;
        o_item.sl   = o_item.bad ? '0 : tlsf_fcb_pkg::SL_IDX_W'(sl_sel);
    end

endmodule

// ----- src/tlsf_fcb_queue.sv -----
// short queue of classified requests between front and back
module tlsf_fcb_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  tlsf_fcb_pkg::t_class_item i_data,
    output logic                      o_full,
    input  logic                      i_pop,
    output logic                      o_empty,
    output tlsf_fcb_pkg::t_class_item o_data
);

    tlsf_fcb_pkg::t_class_item                r_mem [tlsf_fcb_pkg::QUEUE_DEPTH];
    logic [tlsf_fcb_pkg::QUEUE_PTR_W-1:0]     r_wr_ptr;
    logic [tlsf_fcb_pkg::QUEUE_PTR_W-1:0]     r_rd_ptr;
    logic [tlsf_fcb_pkg::QUEUE_CNT_W-1:0]     r_count;
    logic [tlsf_fcb_pkg::QUEUE_PTR_W-1:0]     n_wr_ptr;
    logic [tlsf_fcb_pkg::QUEUE_PTR_W-1:0]     n_rd_ptr;
    logic [tlsf_fcb_pkg::QUEUE_CNT_W-1:0]     n_count;
    logic                                     wr_en;
    logic                                     rd_en;

    assign o_full  = r_count == tlsf_fcb_pkg::QUEUE_CNT_W'(tlsf_fcb_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = r_wr_ptr + tlsf_fcb_pkg::QUEUE_PTR_W'(1);
        end
        if (rd_en) begin
            n_rd_ptr = r_rd_ptr + tlsf_fcb_pkg::QUEUE_PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + tlsf_fcb_pkg::QUEUE_CNT_W'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - tlsf_fcb_pkg::QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- src/tlsf_fcb_back.sv -----
// back end: bitmap store, search, mark and clear, result register
`include "tlsf_free_class_bitmap_engine_unit_macros.svh"

module tlsf_fcb_back #(
    parameter int FIRST_LEVELS      = tlsf_fcb_pkg::DEF_FIRST_LEVELS,
    parameter int SECOND_LEVEL_LOG2 = tlsf_fcb_pkg::DEF_SECOND_LEVEL_LOG2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tlsf_fcb_pkg::t_class_item           i_item,
    input  logic                                i_item_empty,
    output logic                                o_item_pop,
    output logic                                o_empty,
    input  logic                                i_pop,
    output logic [tlsf_fcb_pkg::STATUS_W-1:0]   o_status,
    output logic [tlsf_fcb_pkg::FL_OUT_W-1:0]   o_first_level,
    output logic [tlsf_fcb_pkg::SL_OUT_W-1:0]   o_second_level
);

    localparam int FL_AW   = $clog2(FIRST_LEVELS);
    localparam int SL_AW   = SECOND_LEVEL_LOG2;
    localparam int SL_BITS = 1 << SECOND_LEVEL_LOG2;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    function automatic logic [FL_AW-1:0] f_low_fl(input logic [FIRST_LEVELS-1:0] x);
        logic [FL_AW-1:0] p;
        p = '0;
        for (int i = FIRST_LEVELS - 1; i >= 0; i--) begin
            if (x[i]) begin
                p = FL_AW'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [SL_AW-1:0] f_low_sl(input logic [SL_BITS-1:0] x);
        logic [SL_AW-1:0] p;
        p = '0;
        for (int i = SL_BITS - 1; i >= 0; i--) begin
            if (x[i]) begin
                p = SL_AW'(i);
            end
        end
        return p;
    endfunction

    t_state                          r_state;
    t_state                          n_state;
    logic [FIRST_LEVELS-1:0]         r_l1_map;
    logic [FIRST_LEVELS-1:0]         n_l1_map;
    logic [SL_BITS-1:0]              r_l2_mem [FIRST_LEVELS];
    logic [SL_BITS-1:0]              r_rd_own;
    logic [SL_BITS-1:0]              r_rd_up;
    tlsf_fcb_pkg::t_class_item       r_item;
    logic [FL_AW-1:0]                r_rfl;
    logic                            r_rows_any;
    logic                            r_own_valid;

    logic                            r_out_valid;
    logic                            n_out_valid;
    tlsf_fcb_pkg::t_status           r_out_status;
    logic [tlsf_fcb_pkg::FL_OUT_W-1:0] r_out_fl;
    logic [SL_AW-1:0]                r_out_sl;
    tlsf_fcb_pkg::t_status           res_status;
    logic [tlsf_fcb_pkg::FL_OUT_W-1:0] res_fl;
    logic [SL_AW-1:0]                res_sl;
    logic [tlsf_fcb_pkg::SL_IDX_W-1:0] sl_wide;

    logic [FL_AW-1:0]                head_idx;
    logic [FIRST_LEVELS-1:0]         rows;
    logic [FL_AW-1:0]                rfl;
    logic [FL_AW-1:0]                cur_idx;
    logic [SL_AW-1:0]                cur_sl;
    logic [SL_BITS-1:0]              own;
    logic [SL_BITS-1:0]              own_above;
    logic [SL_BITS-1:0]              bitv;
    logic [SL_BITS-1:0]              wr_data;
    logic                            wr_en;
    logic                            done;

    assign o_item_pop = (r_state == ST_IDLE) && !i_item_empty;
    assign head_idx   = i_item.fl[FL_AW-1:0];
    assign cur_idx    = r_item.fl[FL_AW-1:0];
    assign cur_sl     = r_item.sl[SL_AW-1:0];
    assign done       = (r_state == ST_EXEC) && (!r_out_valid || i_pop);

    // higher non-empty rows for the search
    always_comb begin
        for (int i = 0; i < FIRST_LEVELS; i++) begin
            rows[i] = r_l1_map[i] && (FL_AW'(i) > head_idx);
        end
        rfl = f_low_fl(rows);
    end

    // a row whose first-level bit is clear reads as empty
    always_comb begin
        own  = r_own_valid ? r_rd_own : '0;
        bitv = SL_BITS'(1) << cur_sl;
        for (int i = 0; i < SL_BITS; i++) begin
            own_above[i] = own[i] && (SL_AW'(i) >= cur_sl);
        end
        res_status = tlsf_fcb_pkg::STAT_RANGE;
        res_fl     = '0;
        res_sl     = '0;
        wr_en      = 1'b0;
        wr_data    = own;
        n_l1_map   = r_l1_map;
        if (!r_item.bad) begin
            case (r_item.kind)
                tlsf_fcb_pkg::REQ_SEARCH: begin
                    if (own_above != '0) begin
                        res_status = tlsf_fcb_pkg::STAT_OK;
                        res_fl     = r_item.fl;
                        res_sl     = f_low_sl(own_above);
                    end else if (r_rows_any) begin
                        res_status = tlsf_fcb_pkg::STAT_OK;
                        res_fl     = tlsf_fcb_pkg::FL_OUT_W'(r_rfl);
                        res_sl     = f_low_sl(r_rd_up);
                    end else begin
                        res_status = tlsf_fcb_pkg::STAT_NOFIT;
                        res_fl     = r_item.fl;
                        res_sl     = cur_sl;
                    end
                end
                tlsf_fcb_pkg::REQ_MARK: begin
                    res_status        = tlsf_fcb_pkg::STAT_OK;
                    res_fl            = r_item.fl;
                    res_sl            = cur_sl;
                    wr_en             = done;
                    wr_data           = own | bitv;
                    n_l1_map[cur_idx] = 1'b1;
                end
                tlsf_fcb_pkg::REQ_CLEAR: begin
                    res_status        = tlsf_fcb_pkg::STAT_OK;
                    res_fl            = r_item.fl;
                    res_sl            = cur_sl;
                    wr_en             = done;
                    wr_data           = own & ~bitv;
                    n_l1_map[cur_idx] = wr_data != '0;
                end
                default: begin
                    res_status = tlsf_fcb_pkg::STAT_RANGE;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_item_pop) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (done) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_l1_map    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (done) begin
                r_l1_map <= n_l1_map;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_pop) begin
            r_item      <= i_item;
            r_rfl       <= rfl;
            r_rows_any  <= rows != '0;
            r_own_valid <= r_l1_map[head_idx];
        end
        if (done) begin
            r_out_status <= res_status;
            r_out_fl     <= res_fl;
            r_out_sl     <= res_sl;
        end
    end

    // row store
    always_ff @(posedge i_clk) begin
        if (o_item_pop) begin
            r_rd_own <= r_l2_mem[head_idx];
            r_rd_up  <= r_l2_mem[rfl];
        end
        if (wr_en) begin
            r_l2_mem[cur_idx] <= wr_data;
        end
    end

    assign sl_wide        = tlsf_fcb_pkg::SL_IDX_W'(r_out_sl);
    assign o_empty        = !r_out_valid;
    assign o_status       = r_out_status;
    assign o_first_level  = r_out_fl;
    assign o_second_level = sl_wide[tlsf_fcb_pkg::SL_OUT_W-1:0];

    `TFCB_ASSERT_NEXT(a_exec_delivers, i_clk, i_rst_n, done, !o_empty, "finished request not delivered")
    `TFCB_ASSERT_NEXT(a_stall_holds_exec, i_clk, i_rst_n, (r_state == ST_EXEC) && r_out_valid && !i_pop, r_state == ST_EXEC, "request left exec while result stalled")
    `TFCB_ASSERT_NEXT(a_mark_sets_row, i_clk, i_rst_n, done && (r_item.kind == tlsf_fcb_pkg::REQ_MARK) && !r_item.bad, r_l1_map[$past(cur_idx)], "mark did not set row bit")
    `TFCB_ASSERT_NOW(a_no_pop_in_exec, i_clk, i_rst_n, r_state == ST_EXEC, r_item == $past(r_item) || $past(r_state) == ST_IDLE, "request changed during exec")

endmodule

// ----- src/tlsf_free_class_bitmap_engine_unit.sv -----
// Two-level segregated-fit class and bitmap engine. Requests enter through a
// queue-style port (push/full) and results leave through one (empty/pop), one
// result per request, in order. The front end rounds and maps the size to its
// class in two pipeline stages and takes a new transaction every cycle unless
// the two-entry queue behind it is full. The back end reads the row store as
// it takes a request and runs the search or the bitmap read-modify-write in its
// execute state, held while a result waits to be popped; it takes no new request
// until that row store read-then-update loop is done. A request passes the stage
// a register, the queue, the back end request register and the result register.
// Bitmaps are empty after reset with no clearing pass.
module tlsf_free_class_bitmap_engine_unit #(
    parameter int FIRST_LEVELS      = tlsf_fcb_pkg::DEF_FIRST_LEVELS,
    parameter int SECOND_LEVEL_LOG2 = tlsf_fcb_pkg::DEF_SECOND_LEVEL_LOG2,
    parameter int ALIGN_LOG2_BYTES  = tlsf_fcb_pkg::DEF_ALIGN_LOG2_BYTES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [tlsf_fcb_pkg::REQ_W-1:0]      i_req_type,
    input  logic [tlsf_fcb_pkg::SIZE_W-1:0]     i_size,
    output logic                                empty,
    input  logic                                pop,
    output logic [tlsf_fcb_pkg::STATUS_W-1:0]   o_status,
    output logic [tlsf_fcb_pkg::FL_OUT_W-1:0]   o_first_level,
    output logic [tlsf_fcb_pkg::SL_OUT_W-1:0]   o_second_level
);

    logic                      front_push;
    tlsf_fcb_pkg::t_class_item front_item;
    logic                      q_full;
    logic                      q_empty;
    logic                      q_pop;
    tlsf_fcb_pkg::t_class_item q_item;

    tlsf_fcb_front #(
        .FIRST_LEVELS      (FIRST_LEVELS),
        .SECOND_LEVEL_LOG2 (SECOND_LEVEL_LOG2),
        .ALIGN_LOG2_BYTES  (ALIGN_LOG2_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_req_type  (i_req_type),
        .i_size      (i_size),
        .o_item_push (front_push),
        .o_item      (front_item),
        .i_item_full (q_full)
    );

    tlsf_fcb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_item)
    );

    tlsf_fcb_back #(
        .FIRST_LEVELS      (FIRST_LEVELS),
        .SECOND_LEVEL_LOG2 (SECOND_LEVEL_LOG2)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (q_item),
        .i_item_empty   (q_empty),
        .o_item_pop     (q_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_status       (o_status),
        .o_first_level  (o_first_level),
        .o_second_level (o_second_level)
    );

endmodule
